[hw/rtl/plst_pkg.sv]
// Shared types and constants for the positional list store.
package plst_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		CMD_READ     = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_TAIL = 3'd2,
		CMD_INS_POS  = 3'd3,
		CMD_DELETE   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_RANGE = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// Request to the block mover: copy 'moves' entries one place up or down.
	typedef struct packed {
		logic  start;
		logic  up;
		addr_t first;
		cnt_t  moves;
	} mv_req_t;

	// Memory accesses and status from the block mover.
	typedef struct packed {
		logic  busy;
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		data_t wr_data;
	} mv_port_t;

endpackage

[hw/rtl/plst_ram.sv]
// Simple dual-port entry memory with registered read.
module plst_ram
	import plst_pkg::*;
(
	input  logic  clk,
	input  logic  we,
	input  addr_t waddr,
	input  data_t wdata,
	input  logic  re,
	input  addr_t raddr,
	output data_t rdata
);

	data_t mem [CAPACITY];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/plst_mover.sv]
// Block mover: shifts a run of entries one place up or down through the memory.
module plst_mover
	import plst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mv_req_t  req,
	input  data_t    rdata,
	output mv_port_t port
);

	logic  active_q;
	logic  up_q;
	cnt_t  left_q;
	addr_t rd_addr_q;
	logic  pend_s1;
	addr_t wr_addr_s1;
	logic  rd_en;

	assign rd_en = active_q && (left_q != '0);

	// Walk the read address and count down the remaining moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			up_q      <= 1'b0;
			left_q    <= '0;
			rd_addr_q <= '0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (req.start) begin
				active_q  <= 1'b1;
				up_q      <= req.up;
				left_q    <= req.moves;
				rd_addr_q <= req.first;
			end else if (active_q) begin
				if (left_q == '0) begin
					active_q <= 1'b0;
				end else begin
					left_q    <= left_q - cnt_t'(1);
					rd_addr_q <= up_q ? rd_addr_q - addr_t'(1) : rd_addr_q + addr_t'(1);
				end
			end
		end
	end

	// Hold the target address while the read data is in flight
	always_ff @(posedge clk) begin
		wr_addr_s1 <= up_q ? rd_addr_q + addr_t'(1) : rd_addr_q - addr_t'(1);
	end

	assign port.busy    = active_q | pend_s1;
	assign port.rd_en   = rd_en;
	assign port.rd_addr = rd_addr_q;
	assign port.wr_en   = pend_s1;
	assign port.wr_addr = wr_addr_s1;
	assign port.wr_data = rdata;

endmodule

[hw/rtl/positional_list_store.sv]
// Ordered list of signed 32-bit values held contiguously in one memory.
// An out-of-range or unknown command or a full-store refusal gives its result in the cycle after accept.
// A read in range passes through ST_READ, where the registered memory read data becomes the result.
// Insert or delete: the memory mover shifts each later entry one place, then an insert places its value.
// One command at a time; busy is high until its result is shown.
// Reset clears the entry count and control state; memory contents stay undefined.
module positional_list_store
	import plst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic [CNT_W-1:0]   position,
	input  logic signed [31:0] item_value,
	output logic               done,
	output logic signed [31:0] read_value,
	output logic [1:0]         status,
	output logic [CNT_W-1:0]   entry_count
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_MOVE = 3'b100
	} state_t;

	state_t   state_q;
	cnt_t     count_q;
	logic     is_ins_q;
	addr_t    place_q;
	data_t    value_q;
	logic     accept;
	cmd_t     cmd;
	cnt_t     ins_pos;
	mv_req_t  mv_req;
	mv_port_t mv;
	logic     place_we;
	logic     cmd_re;
	logic     ram_we;
	addr_t    ram_waddr;
	data_t    ram_wdata;
	logic     ram_re;
	addr_t    ram_raddr;
	data_t    ram_rdata;
	logic     finish;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign cmd      = cmd_t'(command);
	assign finish   = (state_q == ST_MOVE) && !mv.busy;
	assign place_we = finish && is_ins_q;

	// Pick the insert position for the three insert forms
	always_comb begin
		case (cmd)
			CMD_INS_HEAD: ins_pos = '0;
			CMD_INS_TAIL: ins_pos = count_q;
			default:      ins_pos = position;
		endcase
	end

	// Decode the command into a mover request or a memory read
	always_comb begin
		mv_req = '0;
		cmd_re = 1'b0;
		if (accept) begin
			case (cmd)
				CMD_READ: begin
					cmd_re = (position < count_q);
				end
				CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
					if ((ins_pos <= count_q) && (count_q != cnt_t'(CAPACITY))) begin
						mv_req.start = 1'b1;
						mv_req.up    = 1'b1;
						mv_req.first = addr_t'(count_q - cnt_t'(1));
						mv_req.moves = count_q - ins_pos;
					end
				end
				CMD_DELETE: begin
					if (position < count_q) begin
						mv_req.start = 1'b1;
						mv_req.up    = 1'b0;
						mv_req.first = addr_t'(position + cnt_t'(1));
						mv_req.moves = count_q - position - cnt_t'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Share the memory ports between mover, value placement and reads
	assign ram_we    = mv.wr_en | place_we;
	assign ram_waddr = place_we ? place_q : mv.wr_addr;
	assign ram_wdata = place_we ? value_q : mv.wr_data;
	assign ram_re    = mv.rd_en | cmd_re;
	assign ram_raddr = cmd_re ? addr_t'(position) : mv.rd_addr;

	plst_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	plst_mover u_mover (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mv_req),
		.rdata  (ram_rdata),
		.port   (mv)
	);

	// Hold the pending insert value and place
	always_ff @(posedge clk) begin
		if (accept) begin
			place_q <= addr_t'(ins_pos);
			value_q <= data_t'(item_value);
		end
	end

	// Sequence the transaction, update the count and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			is_ins_q    <= 1'b0;
			done        <= 1'b0;
			read_value  <= '0;
			status      <= STS_DONE;
			entry_count <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						read_value  <= '0;
						status      <= STS_DONE;
						entry_count <= count_q;
						is_ins_q    <= 1'b0;
						case (cmd)
							CMD_READ: begin
								if (position < count_q) begin
									state_q <= ST_READ;
								end else begin
									done       <= 1'b1;
									read_value <= -32'sd1;
									status     <= STS_RANGE;
								end
							end
							CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
								if (ins_pos > count_q) begin
									done   <= 1'b1;
									status <= STS_RANGE;
								end else if (count_q == cnt_t'(CAPACITY)) begin
									done   <= 1'b1;
									status <= STS_FULL;
								end else begin
									is_ins_q <= 1'b1;
									state_q  <= ST_MOVE;
								end
							end
							CMD_DELETE: begin
								if (position < count_q) begin
									state_q <= ST_MOVE;
								end else begin
									done   <= 1'b1;
									status <= STS_RANGE;
								end
							end
							default: begin
								done   <= 1'b1;
								status <= STS_RANGE;
							end
						endcase
					end
				end
				ST_READ: begin
					done       <= 1'b1;
					read_value <= ram_rdata;
					state_q    <= ST_IDLE;
				end
				ST_MOVE: begin
					if (finish) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
						if (is_ins_q) begin
							count_q     <= count_q + cnt_t'(1);
							entry_count <= count_q + cnt_t'(1);
						end else begin
							count_q     <= count_q - cnt_t'(1);
							entry_count <= count_q - cnt_t'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result strobe only once the transaction has retired
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Mover only runs inside a shift transaction
	a_mover_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		mv.busy |-> (state_q == ST_MOVE))
		else $error("mover active outside shift");

	// Count never exceeds capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("count above capacity");

	// Full refusal only with a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STS_FULL)) |-> (entry_count == cnt_t'(CAPACITY)))
		else $error("full status with room left");

	// No write and read of the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("memory read and write collide");

endmodule

[bench/list_store_checker.sv]
// Checker for the positional list store: predicts each transaction and compares its result.
module list_store_checker
	import plst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         command,
	input  cnt_t               position,
	input  logic signed [31:0] item_value,
	input  logic               done,
	input  logic signed [31:0] read_value,
	input  logic [1:0]         status,
	input  cnt_t               entry_count,
	output int                 fail_count,
	output int                 owed_count,
	output cnt_t               list_len
);

	typedef struct packed {
		logic [2:0] cmd;
		data_t      value;
		status_t    st;
		cnt_t       cnt;
	} list_result_t;

	data_t        list_words [CAPACITY];
	cnt_t         model_len = '0;
	list_result_t owed_results [$];
	list_result_t want;
	list_result_t predicted;
	int           errors = 0;
	int           owed = 0;

	assign fail_count = errors;
	assign owed_count = owed;
	assign list_len   = model_len;

	// Print one line per mismatch (bounded) and count every one
	task report_mismatch(input string what);
		if (errors < 100) begin
			$display("mismatch at %0t: %s", $time, what);
		end
		errors++;
	endtask

	// Apply one command to the list copy and work out the result it gives
	task apply_list_command(input logic [2:0] cmd, input cnt_t pos, input data_t val,
			output list_result_t res);
		int   i;
		logic grow;
		cnt_t slot;
		res.cmd   = cmd;
		res.value = '0;
		res.st    = STS_DONE;
		grow      = 1'b0;
		slot      = '0;
		case (cmd)
			CMD_READ: begin
				if (pos < model_len) begin
					res.value = list_words[pos[ADDR_W-1:0]];
				end else begin
					res.value = '1;
					res.st    = STS_RANGE;
				end
			end
			CMD_INS_HEAD: begin
				grow = 1'b1;
				slot = '0;
			end
			CMD_INS_TAIL: begin
				grow = 1'b1;
				slot = model_len;
			end
			CMD_INS_POS: begin
				// range check wins over the full check
				if (pos > model_len) begin
					res.st = STS_RANGE;
				end else begin
					grow = 1'b1;
					slot = pos;
				end
			end
			CMD_DELETE: begin
				if (pos < model_len) begin
					for (i = pos; i + 1 < model_len; i++) begin
						list_words[i] = list_words[i + 1];
					end
					model_len--;
				end else begin
					res.st = STS_RANGE;
				end
			end
			default: begin
				res.st = STS_RANGE;
			end
		endcase
		// refuse growth of a full store, else shift later entries up and place the value
		if (grow && model_len >= CAPACITY) begin
			res.st = STS_FULL;
		end else if (grow) begin
			for (i = model_len; i > slot; i--) begin
				list_words[i] = list_words[i - 1];
			end
			list_words[slot] = val;
			model_len++;
		end
		res.cnt = model_len;
	endtask

	// Compare each result with the oldest prediction, then predict any new transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_len = '0;
			owed_results.delete();
			owed = 0;
		end else begin
			if (done) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result strobe with no command outstanding");
				end else begin
					want = owed_results.pop_front();
					if (read_value !== want.value) begin
						report_mismatch($sformatf("cmd %0d read_value %0d, predicted %0d",
							want.cmd, read_value, $signed(want.value)));
					end
					if (status !== want.st) begin
						report_mismatch($sformatf("cmd %0d status %0d, predicted %0d",
							want.cmd, status, want.st));
					end
					if (entry_count !== want.cnt) begin
						report_mismatch($sformatf("cmd %0d entry_count %0d, predicted %0d",
							want.cmd, entry_count, want.cnt));
					end
				end
			end
			if (start && !busy) begin
				apply_list_command(command, position, item_value, predicted);
				owed_results.push_back(predicted);
			end
			owed = owed_results.size();
		end
	end

endmodule

[bench/tb_positional_list_store.sv]
// Testbench top for the positional list store: drives command transactions and gives the verdict.
module tb_positional_list_store;
	import plst_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
	localparam int POS_MAX      = (1 << CNT_W) - 1;
	localparam int RANDOM_ITEMS = 580;
	localparam int SETTLE_CYCLES = 1100;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         command;
	cnt_t               position;
	logic signed [31:0] item_value;
	logic               done;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	cnt_t               entry_count;
	int                 fail_count;
	int                 owed_count;
	cnt_t               list_len;
	int                 burst_left;

	positional_list_store u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.position    (position),
		.item_value  (item_value),
		.done        (done),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	list_store_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.position    (position),
		.item_value  (item_value),
		.done        (done),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count),
		.fail_count  (fail_count),
		.owed_count  (owed_count),
		.list_len    (list_len)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle with start low and junk on the fields, n times
	task idle_for(input int n);
		repeat (n) begin
			@(negedge clk);
			start      <= 1'b0;
			command    <= $urandom;
			position   <= $urandom;
			item_value <= $urandom;
		end
	endtask

	// Insert a gap between bursts, then advance to the next falling edge
	task next_slot();
		if (burst_left == 0) begin
			idle_for(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
	endtask

	// Present one transaction and wait for the edge that accepts it
	task drive_command(input logic [2:0] cmd, input cnt_t pos, input logic signed [31:0] val);
		start      <= 1'b1;
		command    <= cmd;
		position   <= pos;
		item_value <= val;
		do @(posedge clk); while (busy);
	endtask

	task issue(input logic [2:0] cmd, input cnt_t pos, input logic signed [31:0] val);
		next_slot();
		drive_command(cmd, pos, val);
	endtask

	// Drop start and hold off until every outstanding result has come back
	task wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (owed_count != 0) @(negedge clk);
	endtask

	initial begin
		int                 k;
		int                 r;
		int                 n;
		int                 len;
		int                 ins_lim;
		int                 depth;
		logic [2:0]         cmd;
		cnt_t               pos;
		logic signed [31:0] val;

		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_READ;
		position   = '0;
		item_value = '0;
		burst_left = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// empty list: reads, deletes and inserts past the end
		issue(CMD_READ, 0, 0);
		issue(CMD_DELETE, 0, 0);
		issue(CMD_INS_POS, 1, 32'h1234_5678);
		// positional insert at the count appends
		issue(CMD_INS_POS, 0, 32'h7fff_ffff);
		issue(CMD_INS_HEAD, POS_MAX, 32'h8000_0000);
		issue(CMD_INS_TAIL, 0, 0);
		issue(CMD_INS_TAIL, 0, -1);
		issue(CMD_INS_POS, 2, 32'h5555_5555);
		for (k = 0; k < 5; k++) begin
			issue(CMD_READ, k, $urandom);
		end
		issue(CMD_READ, 5, 0);
		issue(CMD_READ, POS_MAX, 0);
		issue(CMD_INS_POS, POS_MAX, -1);
		issue(CMD_DELETE, POS_MAX, 0);
		issue(CMD_SPARE_LO, 0, 1);
		issue(CMD_SPARE_MID, 1, 2);
		issue(CMD_SPARE_HI, POS_MAX, -1);
		// delete at head, tail and middle
		issue(CMD_DELETE, 0, 0);
		issue(CMD_DELETE, 3, 0);
		issue(CMD_DELETE, 1, 0);
		issue(CMD_READ, 0, 0);
		issue(CMD_READ, 1, 0);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 2) begin
				// fill the store to capacity with cheap appends
				wait_drained();
				n = CAPACITY - list_len;
				repeat (n) begin
					next_slot();
					if ($urandom_range(0, 7) == 0) begin
						drive_command(CMD_INS_POS, list_len, $urandom);
					end else begin
						drive_command(CMD_INS_TAIL, $urandom_range(0, POS_MAX), $urandom);
					end
				end
				// every insert flavor against a full store
				issue(CMD_INS_HEAD, 0, 32'h7fff_ffff);
				issue(CMD_INS_TAIL, POS_MAX, 32'h8000_0000);
				issue(CMD_INS_POS, 0, 1);
				issue(CMD_INS_POS, CAPACITY, 2);
				issue(CMD_INS_POS, CAPACITY + 1, 3);
				issue(CMD_INS_POS, POS_MAX, 4);
				issue(CMD_READ, 0, 0);
				issue(CMD_READ, CAPACITY - 1, 0);
				issue(CMD_READ, CAPACITY, 0);
				issue(CMD_DELETE, CAPACITY, 0);
				issue(CMD_SPARE_HI, CAPACITY - 1, 0);
				// longest shifts in both directions
				issue(CMD_DELETE, 0, 0);
				issue(CMD_INS_HEAD, 0, $urandom);
				issue(CMD_READ, 0, 0);
				// drain from the tail with short shifts
				repeat (CAPACITY - 16) begin
					next_slot();
					len = list_len;
					if (len == 0) begin
						drive_command(CMD_READ, 0, $urandom);
					end else if ($urandom_range(0, 15) == 0) begin
						drive_command(CMD_READ, $urandom_range(0, len - 1), $urandom);
					end else begin
						depth = (len > 8) ? 7 : len - 1;
						drive_command(CMD_DELETE, len - 1 - $urandom_range(0, depth), $urandom);
					end
				end
			end

			next_slot();
			len     = list_len;
			r       = $urandom_range(0, 99);
			ins_lim = (len < 24) ? 62 : 38;
			if (r < 20) begin
				cmd = CMD_READ;
				pos = (len > 0) ? $urandom_range(0, len - 1) : 0;
			end else if (r < 24) begin
				cmd = CMD_READ;
				pos = $urandom_range(len, POS_MAX);
			end else if (r < ins_lim) begin
				case ($urandom_range(0, 7))
					0, 1: begin
						cmd = CMD_INS_HEAD;
						pos = $urandom_range(0, POS_MAX);
					end
					2, 3: begin
						cmd = CMD_INS_TAIL;
						pos = $urandom_range(0, POS_MAX);
					end
					7: begin
						cmd = CMD_INS_POS;
						pos = $urandom_range(len + 1, POS_MAX);
					end
					default: begin
						cmd = CMD_INS_POS;
						pos = $urandom_range(0, len);
					end
				endcase
			end else if (r < 95) begin
				cmd = CMD_DELETE;
				if (len == 0 || $urandom_range(0, 9) == 0) begin
					pos = $urandom_range(len, POS_MAX);
				end else begin
					pos = $urandom_range(0, len - 1);
				end
			end else begin
				cmd = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
				pos = $urandom_range(0, POS_MAX);
			end
			val = $urandom;
			if ($urandom_range(0, 15) == 0) begin
				val = ($urandom_range(0, 1) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
			end
			drive_command(cmd, pos, val);
		end

		// let the last transaction finish, then watch for stray strobes
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && owed_count == 0) begin
			$display("PASS positional_list_store");
		end else begin
			$display("FAIL positional_list_store");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#100_000_000;
		$display("FAIL positional_list_store");
		$finish;
	end

endmodule
